[design/pdbu_pkg.sv]
`timescale 1ns / 1ps

package pdbu_pkg;

    localparam int CFG_WIDTH  = 32;
    localparam int CHAR_WIDTH = 7;
    localparam int MAX_BASES  = 5;
    localparam int NUM_WIDTH  = 3;
    localparam int BIN_BASES  = 4;

    localparam logic [7:0] ESCAPE_START = 8'd243;

    localparam logic [CHAR_WIDTH-1:0] CHAR_NONE = 7'd0;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A    = 7'd65;
    localparam logic [CHAR_WIDTH-1:0] CHAR_C    = 7'd67;
    localparam logic [CHAR_WIDTH-1:0] CHAR_G    = 7'd71;
    localparam logic [CHAR_WIDTH-1:0] CHAR_T    = 7'd84;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_LOW  = 2'd1,
        ESC_HIGH = 2'd2
    } esc_phase_t;

    typedef enum logic {
        REG_TOTAL = 1'b0,
        REG_MODE  = 1'b1
    } reg_index_t;

    // One decoded item: up to five base chars, or a single status result.
    typedef struct packed {
        logic [MAX_BASES-1:0][CHAR_WIDTH-1:0] chars;
        logic [NUM_WIDTH-1:0]                 count;
        logic                                 is_status;
        status_t                              status;
    } group_t;

    function automatic logic [CHAR_WIDTH-1:0] two_bit_char(input logic [1:0] code);
        logic [CHAR_WIDTH-1:0] ch;
        case (code)
            2'd0:    ch = CHAR_A;
            2'd1:    ch = CHAR_G;
            2'd2:    ch = CHAR_C;
            default: ch = CHAR_T;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] three_char(input logic [1:0] digit);
        logic [CHAR_WIDTH-1:0] ch;
        case (digit)
            2'd0:    ch = CHAR_A;
            2'd1:    ch = CHAR_G;
            default: ch = CHAR_T;
        endcase
        return ch;
    endfunction

    // Five base-3 digits, least significant first, for a byte below 243.
    // Take floor(v / 3^k) for each k from its own multiply and shift, so the
    // digits come out in parallel: 171/512, 57/512, 19/512 and 203/16384.
    function automatic logic [MAX_BASES-1:0][CHAR_WIDTH-1:0] ternary_chars(
        input logic [7:0] v
    );
        logic [MAX_BASES-1:0][CHAR_WIDTH-1:0] chars;
        logic [MAX_BASES-1:0][7:0]            quo;
        logic [16:0]                          wide;
        logic [7:0]                           rem;
        wide   = {9'd0, v};
        quo[0] = v;
        quo[1] = 8'((wide * 17'd171) >> 9);
        quo[2] = 8'((wide * 17'd57) >> 9);
        quo[3] = 8'((wide * 17'd19) >> 9);
        quo[4] = 8'((wide * 17'd203) >> 14);
        for (int k = 0; k < MAX_BASES - 1; k++)
        begin
            rem      = quo[k] - (quo[k+1] + quo[k+1] + quo[k+1]);
            chars[k] = three_char(rem[1:0]);
        end
        chars[MAX_BASES-1] = three_char(quo[MAX_BASES-1][1:0]);
        return chars;
    endfunction

    function automatic logic [MAX_BASES-1:0][CHAR_WIDTH-1:0] word_chars(
        input logic [15:0] w
    );
        logic [MAX_BASES-1:0][CHAR_WIDTH-1:0] chars;
        for (int k = 0; k < MAX_BASES; k++)
        begin
            chars[k] = two_bit_char(w[2*k +: 2]);
        end
        return chars;
    endfunction

    function automatic logic [NUM_WIDTH-1:0] min3(
        input logic [NUM_WIDTH-1:0] a,
        input logic [NUM_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

[design/pdbu_if.sv]
`timescale 1ns / 1ps

interface pdbu_byte_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_value;

    modport source (output valid, output op, output byte_value, input ready);
    modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface pdbu_base_if;
    logic       valid;
    logic       ready;
    logic [6:0] base_char;
    logic       has_base;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output base_char, output has_base, output last,
                    output status, input ready);
    modport sink   (input valid, input base_char, input has_base, input last,
                    input status, output ready);
endinterface

[design/pdbu_decode.sv]
`timescale 1ns / 1ps

module pdbu_decode
    import pdbu_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 op,
    input  logic [7:0]           byte_value,
    input  logic [CFG_WIDTH-1:0] total_bases,
    input  logic                 ternary_mode,
    output logic                 grp_load,
    output group_t               grp
);

    localparam int EXT_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic [COUNT_WIDTH-1:0] bases_done_reg;
    logic [COUNT_WIDTH-1:0] bases_done_next;
    esc_phase_t             escape_phase_reg;
    esc_phase_t             escape_phase_next;
    logic [7:0]             escape_low_reg;
    logic [7:0]             escape_low_next;

    logic [EXT_WIDTH:0]     quota_diff;
    logic [COUNT_WIDTH-1:0] count_left;
    logic [NUM_WIDTH-1:0]   quota_room;
    logic [NUM_WIDTH-1:0]   count_room;
    logic [NUM_WIDTH-1:0]   avail;
    logic [NUM_WIDTH-1:0]   num;

    // Bases still allowed by the quota and by the counter, each capped at five.
    always_comb
    begin
        quota_diff = {1'b0, EXT_WIDTH'(total_bases)} - {1'b0, EXT_WIDTH'(bases_done_reg)};
        count_left = ~bases_done_reg;
        if (quota_diff[EXT_WIDTH])
            quota_room = '0;
        else if ((|quota_diff[EXT_WIDTH-1:NUM_WIDTH])
                 || (quota_diff[NUM_WIDTH-1:0] >= NUM_WIDTH'(MAX_BASES)))
            quota_room = NUM_WIDTH'(MAX_BASES);
        else
            quota_room = quota_diff[NUM_WIDTH-1:0];
        if ((|count_left[COUNT_WIDTH-1:NUM_WIDTH])
            || (count_left[NUM_WIDTH-1:0] >= NUM_WIDTH'(MAX_BASES)))
            count_room = NUM_WIDTH'(MAX_BASES);
        else
            count_room = count_left[NUM_WIDTH-1:0];
        avail = min3(quota_room, count_room);
    end

    always_comb
    begin
        escape_phase_next = escape_phase_reg;
        escape_low_next   = escape_low_reg;
        num               = '0;
        grp.chars         = '0;
        grp.is_status     = 1'b0;
        grp.status        = ST_OK;
        if (op == OP_END)
        begin
            grp.is_status     = 1'b1;
            num               = NUM_WIDTH'(1);
            if (escape_phase_reg != ESC_NONE)
                grp.status = ST_TRUNC;
            else if (EXT_WIDTH'(bases_done_reg) != EXT_WIDTH'(total_bases))
                grp.status = ST_MISMATCH;
            escape_phase_next = ESC_NONE;
            escape_low_next   = '0;
        end
        else if (escape_phase_reg == ESC_LOW)
        begin
            escape_low_next   = byte_value;
            escape_phase_next = ESC_HIGH;
        end
        else if (escape_phase_reg != ESC_NONE)
        begin
            grp.chars         = word_chars({byte_value, escape_low_reg});
            num               = avail;
            escape_phase_next = ESC_NONE;
            escape_low_next   = '0;
        end
        else if (avail == '0)
        begin
            num = '0;
        end
        else if (!ternary_mode)
        begin
            grp.chars = word_chars({8'd0, byte_value});
            num       = min3(NUM_WIDTH'(BIN_BASES), avail);
        end
        else if (byte_value >= ESCAPE_START)
        begin
            escape_phase_next = ESC_LOW;
        end
        else
        begin
            grp.chars = ternary_chars(byte_value);
            num       = avail;
        end
        grp.count = num;
        grp_load  = accept && (num != '0);
        if (op == OP_END)
            bases_done_next = '0;
        else
            bases_done_next = bases_done_reg
                              + (grp.is_status ? '0 : COUNT_WIDTH'(num));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bases_done_reg   <= '0;
            escape_phase_reg <= ESC_NONE;
            escape_low_reg   <= '0;
        end
        else if (accept)
        begin
            bases_done_reg   <= bases_done_next;
            escape_phase_reg <= escape_phase_next;
            escape_low_reg   <= escape_low_next;
        end
    end

endmodule

[design/pdbu_serializer.sv]
`timescale 1ns / 1ps

module pdbu_serializer
    import pdbu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         grp_load,
    input  group_t       grp,
    output logic         free,
    pdbu_base_if.source  base_ch
);

    logic                  grp_valid_reg;
    group_t                grp_reg;
    logic [NUM_WIDTH-1:0]  idx_reg;
    logic                  out_valid_reg;
    logic [CHAR_WIDTH-1:0] base_char_reg;
    logic                  has_base_reg;
    logic                  last_reg;
    status_t               status_reg;

    logic move;
    logic final_one;

    always_comb
    begin
        move      = grp_valid_reg && (!out_valid_reg || base_ch.ready);
        final_one = (idx_reg == grp_reg.count - NUM_WIDTH'(1));
        free      = !grp_valid_reg || (move && final_one);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (grp_load)
            begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (move)
            begin
                if (final_one)
                    grp_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + NUM_WIDTH'(1);
            end
            if (move)
                out_valid_reg <= 1'b1;
            else if (base_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
            grp_reg <= grp;
        if (move)
        begin
            base_char_reg <= grp_reg.is_status ? CHAR_NONE : grp_reg.chars[idx_reg];
            has_base_reg  <= !grp_reg.is_status;
            last_reg      <= final_one;
            status_reg    <= grp_reg.status;
        end
    end

    assign base_ch.valid     = out_valid_reg;
    assign base_ch.base_char = base_char_reg;
    assign base_ch.has_base  = has_base_reg;
    assign base_ch.last      = last_reg;
    assign base_ch.status    = status_reg;

endmodule

[design/packed_dna_base_unpacker.sv]
`timescale 1ns / 1ps

// Packed DNA base unpacker. Each accepted request on packed_ch is decoded into
// a group of up to five results (four per byte in 2-bit mode, five for a
// base-3 byte or an escape word, one status result for an end of chunk). The
// group is then played out on base_ch at one result per cycle while base_ch
// is ready, and no new request is taken until the last result of a group
// moves out; bytes that yield nothing (quota reached, escape start, escape
// low byte) and single results go through at one per cycle while the output
// does not stall. An output register holds the current result, so the next
// group is decoded while it waits. Write total_bases (index 0) and
// ternary_mode (index 1) only while the block is idle.
module packed_dna_base_unpacker
    import pdbu_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pdbu_byte_if.sink            packed_ch,
    pdbu_base_if.source          base_ch,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [CFG_WIDTH-1:0] wr_data
);

    logic [CFG_WIDTH-1:0] total_bases_reg;
    logic                 ternary_mode_reg;
    logic                 accept;
    logic                 grp_load;
    logic                 free;
    group_t               grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bases_reg  <= '0;
            ternary_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TOTAL: total_bases_reg  <= wr_data;
                REG_MODE:  ternary_mode_reg <= wr_data[0];
                default:   ;
            endcase
        end
    end

    assign packed_ch.ready = free;
    assign accept          = packed_ch.valid && free;

    pdbu_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (packed_ch.op),
        .byte_value   (packed_ch.byte_value),
        .total_bases  (total_bases_reg),
        .ternary_mode (ternary_mode_reg),
        .grp_load     (grp_load),
        .grp          (grp)
    );

    pdbu_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_load (grp_load),
        .grp      (grp),
        .free     (free),
        .base_ch  (base_ch)
    );

`ifndef SYNTH
    // A status result carries no base and ends its request.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        base_ch.valid && !base_ch.has_base |-> base_ch.base_char == CHAR_NONE && base_ch.last)
        else $error("status result carries a base or is not last");

    a_base_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        base_ch.valid && base_ch.has_base |-> base_ch.status == ST_OK)
        else $error("base result with nonzero status");

    a_base_char: assert property (@(posedge clk) disable iff (!rst_n)
        base_ch.valid && base_ch.has_base |->
            base_ch.base_char == CHAR_A || base_ch.base_char == CHAR_C
            || base_ch.base_char == CHAR_G || base_ch.base_char == CHAR_T)
        else $error("base result is not a nucleotide");

    // An end-of-chunk request always produces a group to play out.
    a_end_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && packed_ch.op == OP_END |-> grp_load && grp.is_status)
        else $error("end of chunk did not load a status result");
`endif

endmodule

[bench/base_stream_checker.sv]
`timescale 1ns / 1ps

module base_stream_checker
    import pdbu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pdbu_byte_if                 packed_ch,
    pdbu_base_if                 base_ch,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [CFG_WIDTH-1:0] wr_data,
    output int                   errors,
    output int                   pending,
    output int                   requests_seen
);

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] base_char;
        logic                  has_base;
        logic                  last;
        status_t               status;
    } base_result_t;

    base_result_t due_results[$];

    logic [31:0] total_bases = '0;
    logic        ternary     = 1'b0;
    logic [31:0] bases_done  = '0;
    esc_phase_t  esc_phase   = ESC_NONE;
    logic [7:0]  esc_low     = '0;
    int          mismatches  = 0;
    int          seen        = 0;

    function automatic logic [CHAR_WIDTH-1:0] pair_char(logic [1:0] code);
        case (code)
            2'd0:    return CHAR_A;
            2'd1:    return CHAR_G;
            2'd2:    return CHAR_C;
            default: return CHAR_T;
        endcase
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] trit_char(logic [7:0] digit);
        case (digit)
            8'd0:    return CHAR_A;
            8'd1:    return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    // The counter is 32 bits wide, so it also stops at all ones.
    function automatic logic has_room();
        return (bases_done < total_bases) && (bases_done != 32'hFFFF_FFFF);
    endfunction

    function automatic base_result_t emit_base(logic [CHAR_WIDTH-1:0] ch);
        base_result_t res;
        res.base_char = ch;
        res.has_base  = 1'b1;
        res.last      = 1'b0;
        res.status    = ST_OK;
        bases_done++;
        return res;
    endfunction

    function automatic void decode_request(logic op, logic [7:0] b);
        base_result_t grp [MAX_BASES];
        base_result_t res;
        int           n;
        int           k;
        logic [15:0]  word;
        logic [7:0]   v;
        n = 0;
        if (op == OP_END)
        begin
            res.base_char = CHAR_NONE;
            res.has_base  = 1'b0;
            res.last      = 1'b1;
            if (esc_phase != ESC_NONE)
                res.status = ST_TRUNC;
            else if (bases_done != total_bases)
                res.status = ST_MISMATCH;
            else
                res.status = ST_OK;
            due_results = {due_results, res};
            bases_done = '0;
            esc_phase  = ESC_NONE;
            esc_low    = '0;
            return;
        end
        if (esc_phase == ESC_LOW)
        begin
            esc_low   = b;
            esc_phase = ESC_HIGH;
            return;
        end
        if (esc_phase == ESC_HIGH)
        begin
            // escape word decodes regardless of the current mode
            word      = {b, esc_low};
            esc_phase = ESC_NONE;
            esc_low   = '0;
            for (k = 0; k < MAX_BASES && has_room(); k++)
            begin
                grp[n] = emit_base(pair_char(word[2*k +: 2]));
                n++;
            end
        end
        else if (!has_room())
            return;
        else if (!ternary)
        begin
            for (k = 0; k < BIN_BASES && has_room(); k++)
            begin
                grp[n] = emit_base(pair_char(b[2*k +: 2]));
                n++;
            end
        end
        else if (b >= ESCAPE_START)
        begin
            esc_phase = ESC_LOW;
            return;
        end
        else
        begin
            v = b;
            for (k = 0; k < MAX_BASES && has_room(); k++)
            begin
                grp[n] = emit_base(trit_char(v % 8'd3));
                v      = v / 8'd3;
                n++;
            end
        end
        for (k = 0; k < n; k++)
        begin
            res      = grp[k];
            res.last = (k == n - 1);
            due_results = {due_results, res};
        end
    endfunction

    function automatic void check_result();
        base_result_t got;
        base_result_t want;
        got.base_char = base_ch.base_char;
        got.has_base  = base_ch.has_base;
        got.last      = base_ch.last;
        got.status    = status_t'(base_ch.status);
        if (due_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: char=%0d has_base=%b last=%b status=%0d",
                         $time, got.base_char, got.has_base, got.last, got.status);
            return;
        end
        want = due_results.pop_front();
        if (got.base_char !== want.base_char || got.has_base !== want.has_base ||
            got.last !== want.last || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("[%0t] mismatch: want char=%0d has_base=%b last=%b status=%0d, ",
                       $time, want.base_char, want.has_base, want.last, want.status);
                $display("got char=%0d has_base=%b last=%b status=%0d",
                         got.base_char, got.has_base, got.last, got.status);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            total_bases = '0;
            ternary     = 1'b0;
            bases_done  = '0;
            esc_phase   = ESC_NONE;
            esc_low     = '0;
            mismatches  = 0;
            seen        = 0;
            errors        <= 0;
            pending       <= 0;
            requests_seen <= 0;
        end
        else
        begin
            if (base_ch.valid && base_ch.ready)
                check_result();
            if (packed_ch.valid && packed_ch.ready)
            begin
                decode_request(packed_ch.op, packed_ch.byte_value);
                seen++;
            end
            // a write takes effect from the next request on
            if (wr_en)
            begin
                if (wr_index == REG_TOTAL)
                    total_bases = wr_data;
                else
                    ternary = wr_data[0];
            end
            errors        <= mismatches;
            pending       <= due_results.size();
            requests_seen <= seen;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pdbu_pkg::*;

    localparam int RANDOM_REQUESTS = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic                 wr_index;
    logic [CFG_WIDTH-1:0] wr_data;
    logic                 calm;

    int errors;
    int pending;
    int requests_seen;
    int sent;

    pdbu_byte_if packed_ch ();
    pdbu_base_if base_ch ();

    packed_dna_base_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .packed_ch (packed_ch),
        .base_ch   (base_ch),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    base_stream_checker base_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_ch     (packed_ch),
        .base_ch       (base_ch),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .errors        (errors),
        .pending       (pending),
        .requests_seen (requests_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        base_ch.ready <= calm || ($urandom_range(99) >= 24);

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_request(op_t op, logic [7:0] b);
        while (!calm && $urandom_range(99) < 24)
        begin
            packed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        packed_ch.valid      <= 1'b1;
        packed_ch.op         <= op;
        packed_ch.byte_value <= b;
        @(posedge clk);
        while (!packed_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Hold until every request is seen and every result is out, then let
    // requests without results flush through.
    task automatic drain();
        packed_ch.valid <= 1'b0;
        @(posedge clk);
        while (requests_seen != sent || pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] total, logic mode);
        drain();
        wr_en    <= 1'b1;
        wr_index <= REG_TOTAL;
        wr_data  <= total;
        @(posedge clk);
        wr_index <= REG_MODE;
        wr_data  <= {31'd0, mode};
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic send_chunk(logic [31:0] total, logic mode);
        int produced;
        int n;
        produced = 0;
        if ($urandom_range(99) < 75)
        begin
            while (produced < total && produced < 40)
            begin
                if (mode && $urandom_range(99) < 20)
                begin
                    send_request(OP_DATA, 8'($urandom_range(255, 243)));
                    send_request(OP_DATA, 8'($urandom_range(255)));
                    send_request(OP_DATA, 8'($urandom_range(255)));
                end
                else if (mode)
                    send_request(OP_DATA, 8'($urandom_range(242)));
                else
                    send_request(OP_DATA, 8'($urandom_range(255)));
                produced += mode ? MAX_BASES : BIN_BASES;
            end
            // past the quota, unless it is above 40: dropped by the block
            if ($urandom_range(9) == 0)
                send_request(OP_DATA, 8'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(6);
            repeat (n)
                send_request(($urandom_range(9) == 0) ? OP_END : OP_DATA,
                             8'($urandom_range(255)));
            if (mode && $urandom_range(1))
            begin
                send_request(OP_DATA, 8'($urandom_range(255, 243)));
                if ($urandom_range(1))
                    send_request(OP_DATA, 8'($urandom_range(255)));
            end
        end
        send_request(OP_END, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int          random_start;
        int          pick;
        logic [31:0] total;
        logic        mode;

        rst_n                = 1'b0;
        calm                 = 1'b0;
        wr_en                = 1'b0;
        wr_index             = REG_TOTAL;
        wr_data              = '0;
        packed_ch.valid      = 1'b0;
        packed_ch.op         = OP_DATA;
        packed_ch.byte_value = '0;
        sent                 = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero quota: data dropped, end reports ok
        set_config(32'd0, 1'b0);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_END, 8'h00);

        set_config(32'd8, 1'b0);
        send_request(OP_DATA, 8'hE4);
        send_request(OP_DATA, 8'h1B);
        send_request(OP_DATA, 8'hF3);
        send_request(OP_END, 8'hFF);

        // no escape in 2-bit mode; quota cuts the second byte short
        set_config(32'd5, 1'b0);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_DATA, 8'h00);
        send_request(OP_END, 8'h00);

        set_config(32'd12, 1'b1);
        send_request(OP_DATA, 8'd0);
        send_request(OP_DATA, 8'd242);
        send_request(OP_DATA, 8'd243);
        send_request(OP_DATA, 8'h55);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_END, 8'h00);

        // truncated escapes
        set_config(32'd5, 1'b1);
        send_request(OP_DATA, 8'd255);
        send_request(OP_END, 8'h00);
        send_request(OP_DATA, 8'd250);
        send_request(OP_DATA, 8'h12);
        send_request(OP_END, 8'h00);

        set_config(32'hFFFF_FFFF, 1'b1);
        send_request(OP_DATA, 8'd100);
        send_request(OP_END, 8'h00);

        // mode flips to 2-bit while an escape word is pending
        set_config(32'd5, 1'b1);
        send_request(OP_DATA, 8'd244);
        send_request(OP_DATA, 8'h34);
        set_config(32'd5, 1'b0);
        send_request(OP_DATA, 8'hC2);
        send_request(OP_END, 8'h00);

        random_start = sent;
        while (sent - random_start < RANDOM_REQUESTS)
        begin
            calm <= (sent - random_start >= 120) && (sent - random_start < 200);
            pick = $urandom_range(99);
            if (pick < 10)
                total = 32'd0;
            else if (pick < 18)
                total = 32'hFFFF_FFFF;
            else if (pick < 25)
                total = $urandom;
            else
                total = $urandom_range(30, 1);
            mode = 1'($urandom_range(1));
            set_config(total, mode);
            repeat ($urandom_range(3, 1))
                send_chunk(total, mode);
        end
        calm <= 1'b0;
        drain();

        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
